[rtl/gait_trajectory_generator_top_defines.svh]
// Assertion macros for the gait trajectory generator.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef GAIT_TRAJECTORY_GENERATOR_TOP_DEFINES_SVH
`define GAIT_TRAJECTORY_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define GTG_ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("gait generator check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define GTG_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("gait generator check failed");

`else

`define GTG_ASSERT_IMPLIES(lbl, pre, post)
`define GTG_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

[rtl/gtg_pkg.sv]
// Shared types and constants of the gait trajectory generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package gtg_pkg;

  localparam int unsigned EASE_TABLE_DEPTH = 1024;
  localparam int unsigned PHASE_BITS       = 24;
  localparam int unsigned TICK_COUNT_BITS  = 17;
  localparam int unsigned QUEUE_DEPTH      = 4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned ANGLE_W     = 17;
  localparam int unsigned EASE_W      = 16;

  // Pi in Q30 for the ease table builder.
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Register reset values.
  localparam logic [7:0]  RST_ROLL_AMP    = 8'd100;
  localparam logic [7:0]  RST_PITCH_AMP   = 8'd100;
  localparam logic [7:0]  RST_ANKLE_AMP   = 8'd100;
  localparam logic [15:0] RST_MOVE_TICKS  = 16'd8000;
  localparam logic [15:0] RST_HOLD_TICKS  = 16'd2000;
  localparam logic [23:0] RST_ROLL_STEP   = 24'd1678;
  localparam logic [23:0] RST_PITCH_STEP  = 24'd2097;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROLL_AMP,
    REG_PITCH_AMP,
    REG_ANKLE_AMP,
    REG_MOVE_TICKS,
    REG_HOLD_TICKS,
    REG_ROLL_STEP,
    REG_PITCH_STEP
  } gtg_reg_e;

  // Hip roll segments.
  localparam logic [1:0] RSEG_DECAY_POS = 2'd0;
  localparam logic [1:0] RSEG_RISE_NEG  = 2'd1;
  localparam logic [1:0] RSEG_DECAY_NEG = 2'd2;
  localparam logic [1:0] RSEG_RISE_POS  = 2'd3;

  // Hip pitch and ankle segments.
  localparam logic [2:0] PSEG_RISE    = 3'd0;
  localparam logic [2:0] PSEG_HOLD_HI = 3'd1;
  localparam logic [2:0] PSEG_FALL_HI = 3'd2;
  localparam logic [2:0] PSEG_DROP    = 3'd3;
  localparam logic [2:0] PSEG_HOLD_LO = 3'd4;
  localparam logic [2:0] PSEG_RETURN  = 3'd5;

  typedef struct packed {
    logic [7:0]  roll_amp;
    logic [7:0]  pitch_amp;
    logic [7:0]  ankle_amp;
    logic [15:0] move_ticks;
    logic [15:0] hold_ticks;
    logic [23:0] roll_step;
    logic [23:0] pitch_step;
  } gtg_cfg_t;

  // Per-tick control word passed from the sequencer to the datapath.
  typedef struct packed {
    logic       roll_inv;
    logic       roll_neg;
    logic       pitch_inv;
    logic       pitch_neg;
    logic [2:0] pitch_seg;
    logic       cycle_end;
  } gtg_flags_t;

endpackage

`default_nettype wire

[rtl/gtg_front.sv]
// Gait sequencer: segment counters, phase accumulators and ease table indices.
// Depends on gtg_pkg.
`default_nettype none

module gtg_front #(
  parameter int unsigned EaseDepth = 1024,
  parameter int unsigned PhaseBits = 24,
  parameter int unsigned TickBits  = 17,
  parameter int unsigned IdxW      = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gtg_pkg::gtg_cfg_t   cfg_i,
  input  logic                push_i,
  input  logic                restart_i,
  output logic [IdxW-1:0]     roll_idx_o,
  output logic [IdxW-1:0]     pitch_idx_o,
  output gtg_pkg::gtg_flags_t flags_o
);
  import gtg_pkg::*;

  localparam int unsigned SumW  = ((PhaseBits > 24) ? PhaseBits : 24) + 1;
  localparam int unsigned ProdW = PhaseBits + IdxW;

  logic [1:0]           roll_seg_q, roll_seg_d;
  logic [TickBits-1:0]  roll_tick_q, roll_tick_d;
  logic [PhaseBits-1:0] roll_phase_q, roll_phase_d;
  logic [2:0]           pitch_seg_q, pitch_seg_d;
  logic [TickBits-1:0]  pitch_tick_q, pitch_tick_d;
  logic [PhaseBits-1:0] pitch_phase_q, pitch_phase_d;
  logic [IdxW-1:0]      held_idx_q, held_idx_d;

  logic [1:0]           roll_seg;
  logic [TickBits-1:0]  roll_tick;
  logic [PhaseBits-1:0] roll_phase;
  logic [2:0]           pitch_seg;
  logic [TickBits-1:0]  pitch_tick;
  logic [PhaseBits-1:0] pitch_phase;

  logic [15:0]          move_eff;
  logic signed [18:0]   roll_len_m1, hold_len_m1, move_len_m1;
  logic [TickBits-1:0]  roll_last, pitch_last;
  logic                 roll_end, pitch_end, pitch_is_hold;
  logic [SumW-1:0]      roll_sum, pitch_sum;
  logic [PhaseBits-1:0] roll_phase_nx, pitch_phase_nx;
  logic [ProdW-1:0]     roll_prod, pitch_prod;
  logic [IdxW-1:0]      pitch_phase_idx;
  logic [2:0]           pitch_seg_inc;

  // A restart tick is answered from the first tick of the cycle.
  assign roll_seg    = restart_i ? RSEG_DECAY_POS : roll_seg_q;
  assign roll_tick   = restart_i ? '0 : roll_tick_q;
  assign roll_phase  = restart_i ? '0 : roll_phase_q;
  assign pitch_seg   = restart_i ? PSEG_RISE : pitch_seg_q;
  assign pitch_tick  = restart_i ? '0 : pitch_tick_q;
  assign pitch_phase = restart_i ? '0 : pitch_phase_q;

  assign move_eff    = (cfg_i.move_ticks == 16'd0) ? 16'd1 : cfg_i.move_ticks;
  assign roll_len_m1 = signed'({3'b000, move_eff}) + signed'({3'b000, cfg_i.hold_ticks})
                       - 19'sd1;
  assign hold_len_m1 = signed'({2'b00, cfg_i.hold_ticks, 1'b0}) - 19'sd1;
  assign move_len_m1 = signed'({3'b000, move_eff}) - 19'sd1;

  // Segment end values wrap to the counter width; sign extension keeps an
  // empty hold at all ones like the counter itself would.
  assign roll_last     = TickBits'(roll_len_m1);
  assign pitch_is_hold = (pitch_seg == PSEG_HOLD_HI) || (pitch_seg == PSEG_HOLD_LO);
  assign pitch_last    = pitch_is_hold ? TickBits'(hold_len_m1) : TickBits'(move_len_m1);
  assign roll_end      = (roll_tick == roll_last);
  assign pitch_end     = (pitch_tick == pitch_last);

  // Saturating phase accumulators.
  assign roll_sum  = SumW'(roll_phase) + SumW'(cfg_i.roll_step);
  assign pitch_sum = SumW'(pitch_phase) + SumW'(cfg_i.pitch_step);
  assign roll_phase_nx  = (roll_sum[SumW-1:PhaseBits] != '0) ? '1 : roll_sum[PhaseBits-1:0];
  assign pitch_phase_nx = (pitch_sum[SumW-1:PhaseBits] != '0) ? '1
                                                               : pitch_sum[PhaseBits-1:0];

  // Table index is the phase scaled by the table depth.
  assign roll_prod       = ProdW'(roll_phase) * ProdW'(EaseDepth);
  assign pitch_prod      = ProdW'(pitch_phase) * ProdW'(EaseDepth);
  assign roll_idx_o      = roll_prod[ProdW-1:PhaseBits];
  assign pitch_phase_idx = pitch_prod[ProdW-1:PhaseBits];
  // A hold reads the entry latched at the end of the preceding move.
  assign pitch_idx_o     = pitch_is_hold ? held_idx_q : pitch_phase_idx;

  always_comb begin
    pitch_seg_inc = (pitch_seg >= PSEG_RETURN) ? PSEG_RISE : pitch_seg + 3'd1;
    if ((cfg_i.hold_ticks == 16'd0) &&
        ((pitch_seg_inc == PSEG_HOLD_HI) || (pitch_seg_inc == PSEG_HOLD_LO))) begin
      pitch_seg_inc = pitch_seg_inc + 3'd1;
    end
  end

  always_comb begin
    flags_o           = '0;
    flags_o.pitch_seg = pitch_seg;
    flags_o.cycle_end = (roll_seg == RSEG_RISE_POS) && roll_end;
    unique case (roll_seg)
      RSEG_DECAY_POS: begin flags_o.roll_inv = 1'b1; flags_o.roll_neg = 1'b0; end
      RSEG_RISE_NEG:  begin flags_o.roll_inv = 1'b0; flags_o.roll_neg = 1'b1; end
      RSEG_DECAY_NEG: begin flags_o.roll_inv = 1'b1; flags_o.roll_neg = 1'b1; end
      default:        begin flags_o.roll_inv = 1'b0; flags_o.roll_neg = 1'b0; end
    endcase
    unique case (pitch_seg)
      PSEG_RISE, PSEG_HOLD_HI: begin
        flags_o.pitch_inv = 1'b0; flags_o.pitch_neg = 1'b0;
      end
      PSEG_FALL_HI: begin
        flags_o.pitch_inv = 1'b1; flags_o.pitch_neg = 1'b0;
      end
      PSEG_DROP, PSEG_HOLD_LO: begin
        flags_o.pitch_inv = 1'b0; flags_o.pitch_neg = 1'b1;
      end
      default: begin
        flags_o.pitch_inv = 1'b1; flags_o.pitch_neg = 1'b1;
      end
    endcase
  end

  always_comb begin
    roll_seg_d    = roll_seg_q;
    roll_tick_d   = roll_tick_q;
    roll_phase_d  = roll_phase_q;
    pitch_seg_d   = pitch_seg_q;
    pitch_tick_d  = pitch_tick_q;
    pitch_phase_d = pitch_phase_q;
    held_idx_d    = held_idx_q;
    if (push_i) begin
      if (roll_end) begin
        roll_seg_d   = roll_seg + 2'd1;
        roll_tick_d  = '0;
        roll_phase_d = '0;
      end else begin
        roll_seg_d   = roll_seg;
        roll_tick_d  = roll_tick + TickBits'(1);
        roll_phase_d = roll_phase_nx;
      end
      if (pitch_end) begin
        if ((pitch_seg == PSEG_RISE) || (pitch_seg == PSEG_DROP)) begin
          held_idx_d = pitch_phase_idx;
        end
        pitch_seg_d   = pitch_seg_inc;
        pitch_tick_d  = '0;
        pitch_phase_d = '0;
      end else begin
        pitch_seg_d   = pitch_seg;
        pitch_tick_d  = pitch_tick + TickBits'(1);
        pitch_phase_d = pitch_phase_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_seg_q    <= RSEG_DECAY_POS;
      roll_tick_q   <= '0;
      roll_phase_q  <= '0;
      pitch_seg_q   <= PSEG_RISE;
      pitch_tick_q  <= '0;
      pitch_phase_q <= '0;
      held_idx_q    <= '0;
    end else begin
      roll_seg_q    <= roll_seg_d;
      roll_tick_q   <= roll_tick_d;
      roll_phase_q  <= roll_phase_d;
      pitch_seg_q   <= pitch_seg_d;
      pitch_tick_q  <= pitch_tick_d;
      pitch_phase_q <= pitch_phase_d;
      held_idx_q    <= held_idx_d;
    end
  end

endmodule

`default_nettype wire

[rtl/gtg_queue.sv]
// Small register FIFO between the sequencer and the datapath.
// Imports gtg_pkg; its width and depth are the parameters the top level hands down.
`default_nettype none

module gtg_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             not_empty_o,
  output logic             full_o
);
  import gtg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slots_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign data_o      = slots_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign full_o      = (count_q == CntW'(Depth));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

[rtl/gtg_back.sv]
// Set-point datapath: dual-port ease ROM, amplitude scaling and output register.
// Depends on gtg_pkg.
`default_nettype none

module gtg_back #(
  parameter int unsigned EaseDepth = 1024,
  parameter int unsigned IdxW      = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gtg_pkg::gtg_cfg_t            cfg_i,
  input  logic                         head_valid_i,
  input  logic [IdxW-1:0]              roll_idx_i,
  input  logic [IdxW-1:0]              pitch_idx_i,
  input  gtg_pkg::gtg_flags_t          flags_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [gtg_pkg::ANGLE_W-1:0] hip_roll_angle_o,
  output logic signed [gtg_pkg::ANGLE_W-1:0] hip_pitch_angle_o,
  output logic signed [gtg_pkg::ANGLE_W-1:0] ankle_outer_angle_o,
  output logic signed [gtg_pkg::ANGLE_W-1:0] ankle_inner_angle_o,
  output logic [2:0]                   pitch_segment_now_o,
  output logic                         cycle_end_o
);
  import gtg_pkg::*;

  typedef logic [EASE_W-1:0] rom_t [EaseDepth];

  localparam longint unsigned TwoDepth = 2 * longint'(EaseDepth);

  // sin^2 of pi*k/(2*depth) in Q0.16, Taylor series for sine in Q30.
  function automatic longint unsigned sin_sq_q16(longint unsigned k);
    longint unsigned theta, th2, term, sum;
    theta = (PI_Q30 * k) / TwoDepth;
    th2   = (theta * theta) >> 30;
    sum   = theta;
    term  = ((theta * th2) >> 30) / 6;
    sum   = sum - term;
    term  = ((term * th2) >> 30) / 20;
    sum   = sum + term;
    term  = ((term * th2) >> 30) / 42;
    sum   = sum - term;
    term  = ((term * th2) >> 30) / 72;
    sum   = sum + term;
    term  = ((term * th2) >> 30) / 110;
    sum   = sum - term;
    term  = ((term * th2) >> 30) / 156;
    sum   = sum + term;
    return (sum * sum + (64'd1 << 43)) >> 44;
  endfunction

  // The upper half mirrors the lower half around one half.
  function automatic rom_t build_rom();
    rom_t            rom;
    longint unsigned v;
    for (int i = 0; i < EaseDepth; i++) begin
      if (2 * i <= EaseDepth) begin
        v = sin_sq_q16(longint'(i));
      end else begin
        v = 64'd65536 - sin_sq_q16(longint'(EaseDepth - i));
      end
      if (v > 64'd65535) begin
        v = 64'd65535;
      end
      rom[i] = EASE_W'(v);
    end
    return rom;
  endfunction

  localparam rom_t EaseRom = build_rom();

  // Q8.8 magnitude of amp * v, v being e or one minus e.
  function automatic logic [ANGLE_W-1:0] scale(logic [7:0] amp, logic [EASE_W-1:0] e,
                                               logic inv);
    logic [EASE_W:0] v;
    logic [24:0]     prod;
    v    = inv ? (17'h10000 - {1'b0, e}) : {1'b0, e};
    prod = 25'(amp) * 25'(v) + 25'd128;
    return prod[24:8];
  endfunction

  logic              adv;
  logic              s1_valid_q;
  logic [EASE_W-1:0] roll_ease_q, pitch_ease_q;
  gtg_flags_t        s1_flags_q;
  logic [ANGLE_W-1:0] roll_mag, pitch_mag, ankle_mag;
  logic [ANGLE_W-1:0] roll_val, pitch_val, ankle_val;

  // The datapath moves whenever the output register is free or being taken.
  assign adv   = !out_valid_o || !out_stall_i;
  assign pop_o = adv && head_valid_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_ease_q  <= EaseRom[roll_idx_i];
      pitch_ease_q <= EaseRom[pitch_idx_i];
      s1_flags_q   <= flags_i;
    end
  end

  assign roll_mag  = scale(cfg_i.roll_amp, roll_ease_q, s1_flags_q.roll_inv);
  assign pitch_mag = scale(cfg_i.pitch_amp, pitch_ease_q, s1_flags_q.pitch_inv);
  assign ankle_mag = scale(cfg_i.ankle_amp, pitch_ease_q, s1_flags_q.pitch_inv);
  assign roll_val  = s1_flags_q.roll_neg ? (~roll_mag + ANGLE_W'(1)) : roll_mag;
  assign pitch_val = s1_flags_q.pitch_neg ? (~pitch_mag + ANGLE_W'(1)) : pitch_mag;
  assign ankle_val = s1_flags_q.pitch_neg ? (~ankle_mag + ANGLE_W'(1)) : ankle_mag;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hip_roll_angle_o    <= signed'(roll_val);
      hip_pitch_angle_o   <= signed'(pitch_val);
      ankle_outer_angle_o <= signed'(ankle_val);
      ankle_inner_angle_o <= signed'(~ankle_val + ANGLE_W'(1));
      pitch_segment_now_o <= s1_flags_q.pitch_seg;
      cycle_end_o         <= s1_flags_q.cycle_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= head_valid_i;
      out_valid_o <= s1_valid_q;
    end
  end

endmodule

`default_nettype wire

[rtl/gait_trajectory_generator_top.sv]
// Gait trajectory generator top: config registers, sequencer, queue, datapath.
// A tick accepted into the queue passes the ease ROM read stage, then the output
// register; sustained throughput is one tick per cycle while the output is not
// stalled, set by the counter update and the dual-port ease ROM read stage.
// Reset clears counters, queue and pipeline at once; the ease ROM is constant
// and needs no clearing pass. Depends on gtg_pkg and the defines header.
`include "gait_trajectory_generator_top_defines.svh"
`default_nettype none

module gait_trajectory_generator_top #(
  parameter int unsigned EaseTableDepth = gtg_pkg::EASE_TABLE_DEPTH,
  parameter int unsigned PhaseBits      = gtg_pkg::PHASE_BITS,
  parameter int unsigned TickCountBits  = gtg_pkg::TICK_COUNT_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [gtg_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [gtg_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Tick request channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              restart_i,
  // Set-point request channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [gtg_pkg::ANGLE_W-1:0] hip_roll_angle_o,
  output logic signed [gtg_pkg::ANGLE_W-1:0] hip_pitch_angle_o,
  output logic signed [gtg_pkg::ANGLE_W-1:0] ankle_outer_angle_o,
  output logic signed [gtg_pkg::ANGLE_W-1:0] ankle_inner_angle_o,
  output logic [2:0]                        pitch_segment_now_o,
  output logic                              cycle_end_o
);
  import gtg_pkg::*;

  localparam int unsigned IdxW   = $clog2(EaseTableDepth);
  localparam int unsigned FlagW  = $bits(gtg_flags_t);
  localparam int unsigned EntryW = 2 * IdxW + FlagW;
  localparam int unsigned InflW  = $clog2(QUEUE_DEPTH + 3);

  // Configuration registers. The user writes them only while the block is idle
  // (not enforced here), so the sequencer and the datapath read them directly.
  gtg_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roll_amp   <= RST_ROLL_AMP;
      cfg_q.pitch_amp  <= RST_PITCH_AMP;
      cfg_q.ankle_amp  <= RST_ANKLE_AMP;
      cfg_q.move_ticks <= RST_MOVE_TICKS;
      cfg_q.hold_ticks <= RST_HOLD_TICKS;
      cfg_q.roll_step  <= RST_ROLL_STEP;
      cfg_q.pitch_step <= RST_PITCH_STEP;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROLL_AMP:   cfg_q.roll_amp   <= cfg_wdata_i[7:0];
        REG_PITCH_AMP:  cfg_q.pitch_amp  <= cfg_wdata_i[7:0];
        REG_ANKLE_AMP:  cfg_q.ankle_amp  <= cfg_wdata_i[7:0];
        REG_MOVE_TICKS: cfg_q.move_ticks <= cfg_wdata_i[15:0];
        REG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_wdata_i[15:0];
        REG_ROLL_STEP:  cfg_q.roll_step  <= cfg_wdata_i[23:0];
        REG_PITCH_STEP: cfg_q.pitch_step <= cfg_wdata_i[23:0];
        default: begin
          // Writes to unassigned indexes are dropped.
        end
      endcase
    end
  end

  // The front end takes a tick whenever the queue has room. It advances the
  // gait counters in the same cycle and queues the two ROM indices together
  // with the sign and inversion controls for that tick.
  logic             push, pop, q_not_empty, q_full;
  logic [IdxW-1:0]  f_roll_idx, f_pitch_idx, b_roll_idx, b_pitch_idx;
  gtg_flags_t       f_flags, b_flags;
  logic [EntryW-1:0] q_wdata, q_rdata;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  gtg_front #(
    .EaseDepth (EaseTableDepth),
    .PhaseBits (PhaseBits),
    .TickBits  (TickCountBits),
    .IdxW      (IdxW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .restart_i   (restart_i),
    .roll_idx_o  (f_roll_idx),
    .pitch_idx_o (f_pitch_idx),
    .flags_o     (f_flags)
  );

  assign q_wdata = {f_roll_idx, f_pitch_idx, f_flags};

  // The queue decouples the two halves so a stalled consumer does not stop
  // ticks from being accepted until it fills.
  gtg_queue #(
    .Width (EntryW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (q_wdata),
    .pop_i       (pop),
    .data_o      (q_rdata),
    .not_empty_o (q_not_empty),
    .full_o      (q_full)
  );

  assign b_roll_idx  = q_rdata[EntryW-1 -: IdxW];
  assign b_pitch_idx = q_rdata[FlagW +: IdxW];
  assign b_flags     = gtg_flags_t'(q_rdata[FlagW-1:0]);

  // The back end reads both ease values in one ROM stage, then scales them by
  // the amplitudes into the output register.
  gtg_back #(
    .EaseDepth (EaseTableDepth),
    .IdxW      (IdxW)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .head_valid_i        (q_not_empty),
    .roll_idx_i          (b_roll_idx),
    .pitch_idx_i         (b_pitch_idx),
    .flags_i             (b_flags),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .hip_roll_angle_o    (hip_roll_angle_o),
    .hip_pitch_angle_o   (hip_pitch_angle_o),
    .ankle_outer_angle_o (ankle_outer_angle_o),
    .ankle_inner_angle_o (ankle_inner_angle_o),
    .pitch_segment_now_o (pitch_segment_now_o),
    .cycle_end_o         (cycle_end_o)
  );

  // Count of ticks accepted but not yet delivered, for the checks below.
  logic [InflW-1:0] inflight_q;
  logic             delivered;

  assign delivered = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (push && !delivered) begin
      inflight_q <= inflight_q + InflW'(1);
    end else if (delivered && !push) begin
      inflight_q <= inflight_q - InflW'(1);
    end
  end

  // No more ticks in flight than queue slots plus the two pipeline registers.
  `GTG_ASSERT_IMPLIES(a_inflight_bound, 1'b1, inflight_q <= InflW'(QUEUE_DEPTH + 2))
  // Backpressure on the input only when the queue really holds a full load.
  `GTG_ASSERT_IMPLIES(a_stall_means_full, in_stall_o, inflight_q >= InflW'(QUEUE_DEPTH))
  // Every delivered set-point belongs to a tick that was accepted earlier.
  `GTG_ASSERT_IMPLIES(a_no_phantom, out_valid_o, inflight_q != '0)
  // Pitch segment codes above the last segment never reach the outputs.
  `GTG_ASSERT_NEXT(a_segment_range, push, !out_valid_o || (pitch_segment_now_o <= PSEG_RETURN))

endmodule

`default_nettype wire

[dv/gait_trajectory_checker.sv]
// Set-point checker for the gait trajectory generator: watches both request channels,
// predicts every set-point from its own copy of the registers and gait state, and compares.
// Depends on gtg_pkg for the register codes, segment codes, widths and table constants.
module gait_trajectory_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gtg_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [gtg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic                               restart_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [gtg_pkg::ANGLE_W-1:0] hip_roll_angle_i,
  input  logic signed [gtg_pkg::ANGLE_W-1:0] hip_pitch_angle_i,
  input  logic signed [gtg_pkg::ANGLE_W-1:0] ankle_outer_angle_i,
  input  logic signed [gtg_pkg::ANGLE_W-1:0] ankle_inner_angle_i,
  input  logic [2:0]                         pitch_segment_now_i,
  input  logic                               cycle_end_i,
  output int                                 pending_o,
  output int                                 fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gtg_pkg::*;

  localparam logic [16:0] EASE_ONE = 17'h10000;

  typedef struct packed {
    logic [ANGLE_W-1:0] roll;
    logic [ANGLE_W-1:0] pitch;
    logic [ANGLE_W-1:0] outer;
    logic [ANGLE_W-1:0] inner;
    logic [2:0]         seg;
    logic               cyc_end;
  } setpoint_t;

  logic [EASE_W-1:0] ease_rom [EASE_TABLE_DEPTH];

  gtg_cfg_t                   gait_cfg;
  logic [1:0]                 roll_seg;
  logic [TICK_COUNT_BITS-1:0] roll_tick;
  logic [PHASE_BITS-1:0]      roll_phase;
  logic [2:0]                 pitch_seg;
  logic [TICK_COUNT_BITS-1:0] pitch_tick;
  logic [PHASE_BITS-1:0]      pitch_phase;
  logic [EASE_W-1:0]          held_ease;

  setpoint_t setpoints_due[$];
  setpoint_t predicted, want;
  int        n_fail;

  // sin^2 of pi*k/(2*depth) in Q0.16, from a Q30 Taylor series of the sine.
  function automatic longint unsigned sin_sq_q16(longint unsigned k);
    longint unsigned theta, th2, term, acc;
    theta = (PI_Q30 * k) / (2 * EASE_TABLE_DEPTH);
    th2   = (theta * theta) >> 30;
    term  = theta;
    acc   = theta;
    for (longint unsigned n = 1; n <= 6; n++) begin
      term = ((term * th2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n[0]) acc = acc - term;
      else acc = acc + term;
    end
    return (acc * acc + (64'd1 << 43)) >> 44;
  endfunction

  function automatic logic [EASE_W-1:0] ease_entry(longint unsigned i);
    longint unsigned v;
    if (2 * i <= EASE_TABLE_DEPTH) v = sin_sq_q16(i);
    else v = 65536 - sin_sq_q16(EASE_TABLE_DEPTH - i);
    if (v > 65535) v = 65535;
    return v[EASE_W-1:0];
  endfunction

  initial begin
    for (int i = 0; i < EASE_TABLE_DEPTH; i++) ease_rom[i] = ease_entry(i);
  end

  function automatic logic [EASE_W-1:0] ease_of(logic [PHASE_BITS-1:0] phase);
    longint unsigned idx;
    idx = (longint'(phase) * EASE_TABLE_DEPTH) >> PHASE_BITS;
    if (idx >= EASE_TABLE_DEPTH) idx = EASE_TABLE_DEPTH - 1;
    return ease_rom[idx];
  endfunction

  // The phase accumulator saturates instead of wrapping.
  function automatic logic [PHASE_BITS-1:0] phase_step(logic [PHASE_BITS-1:0] p,
                                                       logic [CFG_DATA_W-1:0] inc);
    logic [PHASE_BITS:0] s;
    s = {1'b0, p} + inc;
    return s[PHASE_BITS] ? '1 : s[PHASE_BITS-1:0];
  endfunction

  function automatic logic [ANGLE_W-1:0] scale_angle(logic [7:0] amp, logic [16:0] v,
                                                     logic neg);
    logic [31:0]        mag;
    logic [ANGLE_W-1:0] m;
    mag = (32'(amp) * 32'(v) + 32'd128) >> 8;
    m   = mag[ANGLE_W-1:0];
    return neg ? -m : m;
  endfunction

  task automatic advance_gait(input logic restart, output setpoint_t sp);
    logic [TICK_COUNT_BITS-1:0] m, h, roll_last, pitch_last;
    logic [EASE_W-1:0]          er, ep;
    logic [16:0]                v;
    logic                       neg, roll_wrap;
    m = (gait_cfg.move_ticks == '0) ? TICK_COUNT_BITS'(1)
                                    : TICK_COUNT_BITS'(gait_cfg.move_ticks);
    h = TICK_COUNT_BITS'(gait_cfg.hold_ticks);
    roll_last = TICK_COUNT_BITS'(m + h - 1);
    if (restart) begin
      roll_seg    = RSEG_DECAY_POS;
      roll_tick   = '0;
      roll_phase  = '0;
      pitch_seg   = PSEG_RISE;
      pitch_tick  = '0;
      pitch_phase = '0;
    end
    er = ease_of(roll_phase);
    ep = ease_of(pitch_phase);

    case (roll_seg)
      RSEG_DECAY_POS: sp.roll = scale_angle(gait_cfg.roll_amp, EASE_ONE - er, 1'b0);
      RSEG_RISE_NEG:  sp.roll = scale_angle(gait_cfg.roll_amp, {1'b0, er}, 1'b1);
      RSEG_DECAY_NEG: sp.roll = scale_angle(gait_cfg.roll_amp, EASE_ONE - er, 1'b1);
      default:        sp.roll = scale_angle(gait_cfg.roll_amp, {1'b0, er}, 1'b0);
    endcase

    case (pitch_seg)
      PSEG_RISE:    begin v = {1'b0, ep};        neg = 1'b0; end
      PSEG_HOLD_HI: begin v = {1'b0, held_ease}; neg = 1'b0; end
      PSEG_FALL_HI: begin v = EASE_ONE - ep;     neg = 1'b0; end
      PSEG_DROP:    begin v = {1'b0, ep};        neg = 1'b1; end
      PSEG_HOLD_LO: begin v = {1'b0, held_ease}; neg = 1'b1; end
      default:      begin v = EASE_ONE - ep;     neg = 1'b1; end
    endcase
    sp.pitch = scale_angle(gait_cfg.pitch_amp, v, neg);
    sp.outer = scale_angle(gait_cfg.ankle_amp, v, neg);
    sp.inner = -sp.outer;
    sp.seg   = pitch_seg;
    roll_wrap  = (roll_tick == roll_last);
    sp.cyc_end = (roll_seg == RSEG_RISE_POS) && roll_wrap;

    if (roll_wrap) begin
      roll_seg   = roll_seg + 2'd1;
      roll_tick  = '0;
      roll_phase = '0;
    end else begin
      roll_tick  = roll_tick + TICK_COUNT_BITS'(1);
      roll_phase = phase_step(roll_phase, gait_cfg.roll_step);
    end

    // Hold segments last 2H ticks; with H zero they are skipped at the segment change.
    if (pitch_seg == PSEG_HOLD_HI || pitch_seg == PSEG_HOLD_LO)
      pitch_last = TICK_COUNT_BITS'(2 * h - 1);
    else pitch_last = TICK_COUNT_BITS'(m - 1);
    if (pitch_tick == pitch_last) begin
      if (pitch_seg == PSEG_RISE || pitch_seg == PSEG_DROP) held_ease = ep;
      pitch_seg = (pitch_seg >= PSEG_RETURN) ? PSEG_RISE : pitch_seg + 3'd1;
      if (h == 0 && (pitch_seg == PSEG_HOLD_HI || pitch_seg == PSEG_HOLD_LO))
        pitch_seg = pitch_seg + 3'd1;
      pitch_tick  = '0;
      pitch_phase = '0;
    end else begin
      pitch_tick  = pitch_tick + TICK_COUNT_BITS'(1);
      pitch_phase = phase_step(pitch_phase, gait_cfg.pitch_step);
    end
  endtask

  task automatic compare_field(input string name, input logic [ANGLE_W-1:0] exp_v,
                               input logic [ANGLE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gait_cfg.roll_amp   = RST_ROLL_AMP;
      gait_cfg.pitch_amp  = RST_PITCH_AMP;
      gait_cfg.ankle_amp  = RST_ANKLE_AMP;
      gait_cfg.move_ticks = RST_MOVE_TICKS;
      gait_cfg.hold_ticks = RST_HOLD_TICKS;
      gait_cfg.roll_step  = RST_ROLL_STEP;
      gait_cfg.pitch_step = RST_PITCH_STEP;
      roll_seg    = RSEG_DECAY_POS;
      roll_tick   = '0;
      roll_phase  = '0;
      pitch_seg   = PSEG_RISE;
      pitch_tick  = '0;
      pitch_phase = '0;
      held_ease   = '0;
      setpoints_due.delete();
      n_fail = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (gtg_reg_e'(cfg_index_i))
          REG_ROLL_AMP:   gait_cfg.roll_amp   = cfg_wdata_i[7:0];
          REG_PITCH_AMP:  gait_cfg.pitch_amp  = cfg_wdata_i[7:0];
          REG_ANKLE_AMP:  gait_cfg.ankle_amp  = cfg_wdata_i[7:0];
          REG_MOVE_TICKS: gait_cfg.move_ticks = cfg_wdata_i[15:0];
          REG_HOLD_TICKS: gait_cfg.hold_ticks = cfg_wdata_i[15:0];
          REG_ROLL_STEP:  gait_cfg.roll_step  = cfg_wdata_i;
          REG_PITCH_STEP: gait_cfg.pitch_step = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        advance_gait(restart_i, predicted);
        setpoints_due.push_back(predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        if (setpoints_due.size() == 0) begin
          $error("set-point request with no tick request waiting");
          n_fail++;
        end else begin
          want = setpoints_due.pop_front();
          compare_field("hip_roll_angle", want.roll, hip_roll_angle_i);
          compare_field("hip_pitch_angle", want.pitch, hip_pitch_angle_i);
          compare_field("ankle_outer_angle", want.outer, ankle_outer_angle_i);
          compare_field("ankle_inner_angle", want.inner, ankle_inner_angle_i);
          compare_field("pitch_segment_now", ANGLE_W'(want.seg), ANGLE_W'(pitch_segment_now_i));
          compare_field("cycle_end", ANGLE_W'(want.cyc_end), ANGLE_W'(cycle_end_i));
        end
      end
      pending_o    <= setpoints_due.size();
      fail_count_o <= n_fail;
    end
  end

endmodule

[dv/tb_gait_trajectory_generator_top.sv]
// Testbench top for the gait trajectory generator: clock, reset, register programming,
// tick requests and set-point back-pressure. Depends on gtg_pkg, the RTL top and the checker.
module tb_gait_trajectory_generator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gtg_pkg::*;

  // Far above the slowest legal run: every request behind a full sender gap and a full
  // receiver stall, plus the drains between register phases.
  localparam int unsigned CYCLE_LIMIT = 500_000;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      restart_i   = 1'b0;
  logic                      out_stall_i = 1'b0;
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic signed [ANGLE_W-1:0] hip_roll_angle_o;
  logic signed [ANGLE_W-1:0] hip_pitch_angle_o;
  logic signed [ANGLE_W-1:0] ankle_outer_angle_o;
  logic signed [ANGLE_W-1:0] ankle_inner_angle_o;
  logic [2:0]                pitch_segment_now_o;
  logic                      cycle_end_o;

  int          setpoints_pending;
  int          fail_count;
  int          ticks_sent  = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_en  = 1'b1;
  bit          rx_idle_en  = 1'b1;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  gait_trajectory_generator_top u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .restart_i,
    .out_valid_o,
    .out_stall_i,
    .hip_roll_angle_o,
    .hip_pitch_angle_o,
    .ankle_outer_angle_o,
    .ankle_inner_angle_o,
    .pitch_segment_now_o,
    .cycle_end_o
  );

  gait_trajectory_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_i          (in_stall_o),
    .restart_i,
    .out_valid_i         (out_valid_o),
    .out_stall_i,
    .hip_roll_angle_i    (hip_roll_angle_o),
    .hip_pitch_angle_i   (hip_pitch_angle_o),
    .ankle_outer_angle_i (ankle_outer_angle_o),
    .ankle_inner_angle_i (ankle_inner_angle_o),
    .pitch_segment_now_i (pitch_segment_now_o),
    .cycle_end_i         (cycle_end_o),
    .pending_o           (setpoints_pending),
    .fail_count_o        (fail_count)
  );

  // Watchdog: a hung handshake or a lost set-point ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL gait_trajectory_generator_top");
      $finish;
    end
  end

  // Set-point receiver. Stall bursts alternate with free stretches, so back-pressure
  // lands on every stage of the pipeline. When rx_idle_en is low the receiver never
  // stalls, and a burst in progress ends at the next edge.
  initial begin
    forever begin
      if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) begin
          @(posedge clk_i);
          if (!rx_idle_en) break;
        end
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // One register write per clock edge. The enable stays high across a batch of writes
  // and is lowered by the caller once the batch is done.
  task automatic write_reg(input gtg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Programs every register. Only called while nothing is in flight.
  task automatic program_gait(input logic [7:0] roll_amp, input logic [7:0] pitch_amp,
                              input logic [7:0] ankle_amp, input logic [15:0] move,
                              input logic [15:0] hold, input logic [23:0] roll_step,
                              input logic [23:0] pitch_step);
    write_reg(REG_ROLL_AMP, CFG_DATA_W'(roll_amp));
    write_reg(REG_PITCH_AMP, CFG_DATA_W'(pitch_amp));
    write_reg(REG_ANKLE_AMP, CFG_DATA_W'(ankle_amp));
    write_reg(REG_MOVE_TICKS, CFG_DATA_W'(move));
    write_reg(REG_HOLD_TICKS, CFG_DATA_W'(hold));
    write_reg(REG_ROLL_STEP, roll_step);
    write_reg(REG_PITCH_STEP, pitch_step);
    cfg_we_i <= 1'b0;
  endtask

  // Sends one tick request, optionally behind a sender gap, and returns at the edge
  // where the block accepts it. Valid is left high so back-to-back requests need no
  // second assignment in the same step.
  task automatic send_tick(input logic restart);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    ticks_sent++;
  endtask

  // Stops sending and waits until every predicted set-point has come back. The first
  // edge lets the checker count a request accepted at the edge we were called on.
  task automatic wait_setpoints_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (setpoints_pending != 0) @(posedge clk_i);
  endtask

  // Drain, then let the pipeline settle before touching registers.
  task automatic drain();
    wait_setpoints_done();
    repeat (8) @(posedge clk_i);
  endtask

  // One register setting followed by a run of ticks. Most settings use short segments
  // so many full gait cycles, hold segments and cycle ends are crossed. The run starts
  // with a restart so the counters fit the new lengths; later restarts are rare noise.
  task automatic run_random_phase(input int n_ticks, input bit quiet);
    logic [15:0] move, hold;
    logic [23:0] roll_step, pitch_step;
    logic [7:0]  amp [3];
    int unsigned eff_move, pick, pause_at;
    pick = $urandom_range(0, 9);
    if (pick < 7) move = 16'($urandom_range(1, 12));
    else if (pick == 7) move = 16'd0;
    else move = 16'($urandom_range(13, 200));
    pick = $urandom_range(0, 9);
    if (pick < 3) hold = 16'd0;
    else if (pick < 8) hold = 16'($urandom_range(1, 6));
    else hold = 16'($urandom_range(7, 100));
    eff_move = (move == 0) ? 1 : move;
    if ($urandom_range(0, 9) < 7) begin
      // Steps matched to the segment lengths, as software would program them.
      roll_step  = ((32'd1 << 24) / (eff_move + hold) > 32'hFFFFFF) ? 24'hFFFFFF :
                   24'((32'd1 << 24) / (eff_move + hold));
      pitch_step = ((32'd1 << 24) / eff_move > 32'hFFFFFF) ? 24'hFFFFFF :
                   24'((32'd1 << 24) / eff_move);
    end else begin
      roll_step  = 24'($urandom_range(1, 24'hFFFFFF));
      pitch_step = 24'($urandom_range(1, 24'hFFFFFF));
    end
    foreach (amp[j]) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) amp[j] = 8'd0;
      else if (pick == 1) amp[j] = 8'd180;
      else amp[j] = 8'($urandom_range(0, 180));
    end
    if (quiet) begin
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
    end else begin
      tx_idle_en = ($urandom_range(0, 4) != 0);
      rx_idle_en = ($urandom_range(0, 4) != 0);
    end
    program_gait(amp[0], amp[1], amp[2], move, hold, roll_step, pitch_step);
    pause_at = quiet ? n_ticks : $urandom_range(5, n_ticks / 2);
    for (int k = 0; k < n_ticks; k++) begin
      send_tick(k == 0 || $urandom_range(0, 49) == 0);
      // Mid-cycle pause until the pipeline is empty, then carry on with the same gait.
      if (k == pause_at) wait_setpoints_done();
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings straight out of reset, then a restart of the cycle.
    repeat (4) send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // Largest amplitudes, zero move ticks (treated as one), zero hold ticks (holds
    // skipped) and maximal steps, though each segment ends on its first tick and its
    // phase stays at zero. The four-tick cycle covers every roll segment and a cycle end.
    program_gait(8'd180, 8'd180, 8'd180, 16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF);
    send_tick(1'b1);
    repeat (7) send_tick(1'b0);
    drain();

    // Zero amplitudes, minimal steps, and hold ticks set to one: one full cycle of twelve
    // ticks visits all six pitch segments including both holds.
    program_gait(8'd0, 8'd0, 8'd0, 16'd2, 16'd1, 24'd1, 24'd1);
    send_tick(1'b1);
    repeat (11) send_tick(1'b0);
    drain();

    // Longest segments; only a few ticks, since a full cycle would take half a million.
    program_gait(8'd180, 8'd90, 8'd45, 16'hFFFF, 16'hFFFF, 24'd128, 24'd256);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    drain();

    while (ticks_sent < 1350) run_random_phase($urandom_range(60, 140), 1'b0);

    // Closing stretch at full rate on both sides.
    run_random_phase(150, 1'b1);

    if (fail_count == 0) begin
      $display("PASS gait_trajectory_generator_top");
    end else begin
      $display("FAIL gait_trajectory_generator_top");
    end
    $finish;
  end

endmodule
